// ----- rtl/rss_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rss_pkg: shared types and constants of the selection sampler
// Field widths, configuration register indexes, datapath opcodes and the
// command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package rss_pkg;

  localparam int COUNT_WIDTH_DEF = 16;

  localparam int SIZE_W  = 16;
  localparam int TAG_W   = 32;
  localparam int INDEX_W = 16;
  localparam int PCT_W   = 7;
  localparam int RNG_W   = 64;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_PERCENT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PIC = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED    = 2'd2;

  localparam logic [PCT_W-1:0]  PCT_FULL    = 7'd100;
  localparam logic [PCT_W-1:0]  PCT_RESET   = 7'd100;
  localparam logic [7:0]        ROUND_HALF  = 8'd50;
  // ceil(2^37 / 100): exact floor division by 100 for values below 2^32
  localparam logic [31:0]       RECIP_100   = 32'h51EB851F;
  localparam int                RECIP_SHIFT = 37;

  localparam logic [63:0] GOLDEN = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;

  typedef logic [3:0] op_t;
  localparam op_t OP_NONE    = 4'd0;
  localparam op_t OP_LOAD    = 4'd1;
  localparam op_t OP_TGT_MUL = 4'd2;
  localparam op_t OP_TGT_DIV = 4'd3;
  localparam op_t OP_TGT_FIN = 4'd4;
  localparam op_t OP_SKIP    = 4'd5;
  localparam op_t OP_RNG     = 4'd6;
  localparam op_t OP_MUL1    = 4'd7;
  localparam op_t OP_MIX27   = 4'd8;
  localparam op_t OP_MUL2    = 4'd9;
  localparam op_t OP_MIX31   = 4'd10;
  localparam op_t OP_DIV     = 4'd11;
  localparam op_t OP_DECIDE  = 4'd12;
  localparam op_t OP_EMIT    = 4'd13;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic first;
    logic seen_ge_size;
    logic need_draw;
    logic mul_last;
    logic div_last;
    logic reject;
    logic keep;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ----- rtl/rss_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rss_in_if / rss_out_if: item channels of the selection sampler
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface rss_in_if;
  logic                        valid;
  logic                        ready;
  logic                        first_of_group;
  logic [rss_pkg::SIZE_W-1:0]  group_size;
  logic [rss_pkg::TAG_W-1:0]   item_tag;

  modport source (output valid, first_of_group, group_size, item_tag, input ready);
  modport sink   (input valid, first_of_group, group_size, item_tag, output ready);
endinterface

interface rss_out_if;
  logic                        valid;
  logic                        ready;
  logic [rss_pkg::TAG_W-1:0]   kept_tag;
  logic [rss_pkg::INDEX_W-1:0] sample_index;
  logic                        last_of_sample;

  modport source (output valid, kept_tag, sample_index, last_of_sample, input ready);
  modport sink   (input valid, kept_tag, sample_index, last_of_sample, output ready);
endinterface
`default_nettype wire

// ----- rtl/rss_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rss_ctrl: sequencer of the selection sampler
// Steps one item through target set-up, draw, rejection and emit.
// ----------------------------------------------------------------------------
module rss_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire rss_pkg::sts_t sts,
  output rss_pkg::cmd_t      cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_TGT_MUL = 4'd1;
  localparam logic [3:0] S_TGT_DIV = 4'd2;
  localparam logic [3:0] S_TGT_FIN = 4'd3;
  localparam logic [3:0] S_CHECK   = 4'd4;
  localparam logic [3:0] S_RNG     = 4'd5;
  localparam logic [3:0] S_MUL1    = 4'd6;
  localparam logic [3:0] S_MIX27   = 4'd7;
  localparam logic [3:0] S_MUL2    = 4'd8;
  localparam logic [3:0] S_MIX31   = 4'd9;
  localparam logic [3:0] S_DIV     = 4'd10;
  localparam logic [3:0] S_DECIDE  = 4'd11;
  localparam logic [3:0] S_EMIT    = 4'd12;

  logic [3:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd.op    = rss_pkg::OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = rss_pkg::OP_LOAD;
          state_nxt = sts.first ? S_TGT_MUL : S_CHECK;
        end
      end
      S_TGT_MUL: begin
        cmd.op    = rss_pkg::OP_TGT_MUL;
        state_nxt = S_TGT_DIV;
      end
      S_TGT_DIV: begin
        cmd.op    = rss_pkg::OP_TGT_DIV;
        state_nxt = S_TGT_FIN;
      end
      S_TGT_FIN: begin
        cmd.op    = rss_pkg::OP_TGT_FIN;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        priority if (sts.seen_ge_size) begin
          state_nxt = S_IDLE;
        end else if (sts.need_draw) begin
          state_nxt = S_RNG;
        end else begin
          cmd.op    = rss_pkg::OP_SKIP;
          state_nxt = S_IDLE;
        end
      end
      S_RNG: begin
        cmd.op    = rss_pkg::OP_RNG;
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        cmd.op = rss_pkg::OP_MUL1;
        if (sts.mul_last) state_nxt = S_MIX27;
      end
      S_MIX27: begin
        cmd.op    = rss_pkg::OP_MIX27;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.op = rss_pkg::OP_MUL2;
        if (sts.mul_last) state_nxt = S_MIX31;
      end
      S_MIX31: begin
        cmd.op    = rss_pkg::OP_MIX31;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op = rss_pkg::OP_DIV;
        if (sts.div_last) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts.reject) begin
          state_nxt = S_RNG;
        end else begin
          cmd.op    = rss_pkg::OP_DECIDE;
          state_nxt = sts.keep ? S_EMIT : S_IDLE;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.op    = rss_pkg::OP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  a_emit_from_decide: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> ($past(state_r) == S_EMIT || $past(state_r) == S_DECIDE))
    else $error("emit entered without a decision");
  a_draw_after_check: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK && !sts.seen_ge_size && sts.need_draw) |=> (state_r == S_RNG))
    else $error("draw not started");
  a_idle_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ready && in_valid) |-> (cmd.op == rss_pkg::OP_LOAD))
    else $error("item accepted without load");

endmodule
`default_nettype wire

// ----- rtl/rss_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rss_dp: datapath of the selection sampler
// Config registers, group counters, splitmix64 with a shared 32x32
// multiplier, bit-serial remainder unit and the output register.
// ----------------------------------------------------------------------------
module rss_dp #(
  parameter int COUNT_WIDTH = rss_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire rss_pkg::cmd_t                     cmd,
  output rss_pkg::sts_t                          sts,
  input  wire logic                              cfg_we,
  input  wire logic [rss_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [rss_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire logic                              in_first,
  input  wire logic [rss_pkg::SIZE_W-1:0]        in_size,
  input  wire logic [rss_pkg::TAG_W-1:0]         in_tag,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [rss_pkg::TAG_W-1:0]              out_tag,
  output logic [rss_pkg::INDEX_W-1:0]            out_index,
  output logic                                   out_last
);

  localparam int CW = COUNT_WIDTH;

  logic [rss_pkg::PCT_W-1:0]  percent_r, pct_eff_r;
  logic [rss_pkg::SIZE_W-1:0] maxp_r;
  logic [rss_pkg::RNG_W-1:0]  rng_r, a_r, acc_r, x_r, dvd_r;
  logic [CW-1:0]              size_r, seen_r, picked_r, target_r, rem_r;
  logic [rss_pkg::TAG_W-1:0]  tag_r;
  logic [22:0]                prod_r;
  logic [rss_pkg::SIZE_W-1:0] q_r;
  logic [5:0]                 cnt_r;
  logic                       out_valid_r, last_r;
  logic [rss_pkg::TAG_W-1:0]  out_tag_r;
  logic [rss_pkg::INDEX_W-1:0] out_index_r;

  logic [CW-1:0]              m, need, picked_inc;
  logic [rss_pkg::RNG_W-1:0]  rng_add, mix_b, mul_acc;
  logic [31:0]                ma, mb;
  logic [63:0]                mprod;
  logic [CW:0]                div_t;
  logic [rss_pkg::RNG_W:0]    blk_end;
  logic [54:0]                qprod;
  logic [rss_pkg::SIZE_W-1:0] n16, k_pct, k_cap;

  assign m          = size_r - seen_r;
  assign need       = target_r - picked_r;
  assign picked_inc = picked_r + 1'b1;
  assign rng_add    = rng_r + rss_pkg::GOLDEN;
  assign n16        = rss_pkg::SIZE_W'(size_r);

  // 64x64 low product as three 32x32 partial products
  assign mix_b = (cmd.op == rss_pkg::OP_MUL2) ? rss_pkg::MIX_C2 : rss_pkg::MIX_C1;
  always_comb begin
    unique case (cnt_r[1:0])
      2'd0:    begin ma = a_r[31:0];  mb = mix_b[31:0];  end
      2'd1:    begin ma = a_r[31:0];  mb = mix_b[63:32]; end
      default: begin ma = a_r[63:32]; mb = mix_b[31:0];  end
    endcase
  end
  assign mprod   = 64'(ma) * 64'(mb);
  assign mul_acc = (cnt_r == 6'd0) ? mprod : acc_r + {mprod[31:0], 32'd0};

  assign div_t   = {rem_r, dvd_r[63]};
  assign blk_end = {1'b0, x_r} - (rss_pkg::RNG_W+1)'(rem_r) + (rss_pkg::RNG_W+1)'(m);

  assign qprod = 55'(prod_r + 23'(rss_pkg::ROUND_HALF)) * 55'(rss_pkg::RECIP_100);

  always_comb begin
    k_pct = n16;
    if (pct_eff_r < rss_pkg::PCT_FULL) begin
      k_pct = (q_r == '0 && n16 != '0) ? 16'd1 : q_r;
    end
    k_cap = (maxp_r != '0 && k_pct > maxp_r) ? maxp_r : k_pct;
  end

  always_comb begin
    sts.first        = in_first;
    sts.seen_ge_size = (seen_r >= size_r);
    sts.need_draw    = (picked_r < target_r);
    sts.mul_last     = (cnt_r == 6'd2);
    sts.div_last     = (cnt_r == 6'd63);
    sts.reject       = blk_end[rss_pkg::RNG_W];
    sts.keep         = (rem_r < need);
    sts.out_free     = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      percent_r <= rss_pkg::PCT_RESET;
      maxp_r    <= '0;
      rng_r     <= '0;
      size_r    <= '0;
      seen_r    <= '0;
      picked_r  <= '0;
      target_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          rss_pkg::CFG_PERCENT: percent_r <= cfg_wdata[rss_pkg::PCT_W-1:0];
          rss_pkg::CFG_MAX_PIC: maxp_r    <= cfg_wdata[rss_pkg::SIZE_W-1:0];
          rss_pkg::CFG_SEED:    rng_r     <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.op == rss_pkg::OP_LOAD && in_first) begin
        size_r   <= CW'(in_size);
        seen_r   <= '0;
        picked_r <= '0;
      end
      if (cmd.op == rss_pkg::OP_TGT_FIN) target_r <= CW'(k_cap);
      if (cmd.op == rss_pkg::OP_SKIP || cmd.op == rss_pkg::OP_DECIDE) seen_r <= seen_r + 1'b1;
      if (cmd.op == rss_pkg::OP_RNG) rng_r <= rng_add;
      if (cmd.op == rss_pkg::OP_EMIT) begin
        picked_r    <= picked_inc;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      rss_pkg::OP_LOAD:    tag_r <= in_tag;
      rss_pkg::OP_TGT_MUL: begin
        pct_eff_r <= (percent_r == '0 || percent_r > rss_pkg::PCT_FULL) ?
                     rss_pkg::PCT_FULL : percent_r;
        prod_r    <= 23'(n16) * 23'((percent_r == '0 || percent_r > rss_pkg::PCT_FULL) ?
                     rss_pkg::PCT_FULL : percent_r);
      end
      rss_pkg::OP_TGT_DIV: q_r <= qprod[rss_pkg::RECIP_SHIFT +: rss_pkg::SIZE_W];
      rss_pkg::OP_RNG: begin
        a_r   <= rng_add ^ (rng_add >> 30);
        cnt_r <= '0;
      end
      rss_pkg::OP_MUL1, rss_pkg::OP_MUL2: begin
        acc_r <= mul_acc;
        cnt_r <= cnt_r + 1'b1;
      end
      rss_pkg::OP_MIX27: begin
        a_r   <= acc_r ^ (acc_r >> 27);
        cnt_r <= '0;
      end
      rss_pkg::OP_MIX31: begin
        x_r   <= acc_r ^ (acc_r >> 31);
        dvd_r <= acc_r ^ (acc_r >> 31);
        rem_r <= '0;
        cnt_r <= '0;
      end
      rss_pkg::OP_DIV: begin
        rem_r <= (div_t >= {1'b0, m}) ? CW'(div_t - {1'b0, m}) : CW'(div_t);
        dvd_r <= {dvd_r[62:0], 1'b0};
        cnt_r <= cnt_r + 1'b1;
      end
      rss_pkg::OP_EMIT: begin
        out_tag_r   <= tag_r;
        out_index_r <= rss_pkg::INDEX_W'(picked_r);
        last_r      <= (picked_inc == target_r);
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_tag   = out_tag_r;
  assign out_index = out_index_r;
  assign out_last  = last_r;

  a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == rss_pkg::OP_EMIT) |=> out_valid_r)
    else $error("emit lost");
  a_picked_bound: assert property (@(posedge clk) disable iff (!rst_n)
    picked_r <= target_r)
    else $error("picked count past target");
  a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r <= size_r)
    else $error("seen count past group size");
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == rss_pkg::OP_DIV) |=> (rem_r < m))
    else $error("remainder out of range");

endmodule
`default_nettype wire

// ----- rtl/random_selection_sampler_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// random_selection_sampler_core: streaming selection sampler
// Keeps k items of each group, each with probability needed/left, using a
// splitmix64 draw with an unbiased rejection-sampled modulo.
// ----------------------------------------------------------------------------
// One item at a time. An item that needs no draw is loaded and checked; a
// first item adds the target-count set-up (multiply, divide, finish). An
// item that needs a draw also steps through the generator, the remainder
// unit and the decision, and the emit when it is kept: the 64-bit generator
// runs two products on one 32x32 multiplier as three partial products each,
// then the remainder unit takes one dividend bit per cycle. A rejected draw
// repeats that loop, which is rare for any group size. A kept item waits in
// the output register while the next item is taken in; a kept item that
// finds the output register still full stalls until it is taken.
module random_selection_sampler_core #(
  parameter int COUNT_WIDTH = rss_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [rss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rss_pkg::CFG_DATA_W-1:0] cfg_wdata,
  rss_in_if.sink                              in_ch,
  rss_out_if.source                           out_ch
);

  rss_pkg::cmd_t cmd;
  rss_pkg::sts_t sts;

  rss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rss_dp #(.COUNT_WIDTH(COUNT_WIDTH)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_first  (in_ch.first_of_group),
    .in_size   (in_ch.group_size),
    .in_tag    (in_ch.item_tag),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_tag   (out_ch.kept_tag),
    .out_index (out_ch.sample_index),
    .out_last  (out_ch.last_of_sample)
  );

endmodule
`default_nettype wire

// ----- dv/rss_sampler_sb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rss_sampler_sb: expected-sample tracker for the selection sampler
// Mirrors the sampler state (splitmix64 generator, group counters) and keeps
// a queue of expected kept items that results are checked against in order.
// ----------------------------------------------------------------------------
class rss_sampler_sb;
  typedef struct packed {
    logic [31:0] kept_tag;
    logic [15:0] sample_index;
    logic        last_of_sample;
  } kept_item_t;

  logic [6:0]  pct;
  logic [15:0] cap;
  logic [63:0] gen_state;
  logic [15:0] seen;
  logic [15:0] picked;
  logic [15:0] target;
  logic [15:0] grp_size;
  kept_item_t  pending[$];
  int          n_errors;

  function new();
    pct = rss_pkg::PCT_RESET;
    cap = 0;
    gen_state = 0;
    seen = 0;
    picked = 0;
    target = 0;
    grp_size = 0;
    n_errors = 0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [63:0] val);
    if (idx == rss_pkg::CFG_PERCENT) pct = val[6:0];
    else if (idx == rss_pkg::CFG_MAX_PIC) cap = val[15:0];
    else if (idx == rss_pkg::CFG_SEED) gen_state = val;
  endfunction

  function logic [63:0] mix_next();
    logic [63:0] z;
    gen_state = gen_state + 64'h9e3779b97f4a7c15;
    z = gen_state;
    z = (z ^ (z >> 30)) * 64'hbf58476d1ce4e5b9;
    z = (z ^ (z >> 27)) * 64'h94d049bb133111eb;
    return z ^ (z >> 31);
  endfunction

  function logic [63:0] draw_below(logic [63:0] m);
    logic [63:0] bound;
    logic [63:0] x;
    bound = 64'hFFFF_FFFF_FFFF_FFFF - (64'hFFFF_FFFF_FFFF_FFFF % m);
    do x = mix_next(); while (x >= bound);
    return x % m;
  endfunction

  function logic [15:0] group_target(logic [15:0] n);
    logic [63:0] k;
    logic [63:0] p;
    k = n;
    p = pct;
    if (p == 0 || p > 100) p = 100;
    if (p < 100) begin
      k = (n * p + 50) / 100;
      if (k == 0 && n > 0) k = 1;
    end
    if (cap > 0 && k > cap) k = cap;
    return k[15:0];
  endfunction

  function void note_item(logic first, logic [15:0] size, logic [31:0] tag);
    logic keep;
    kept_item_t e;
    keep = 0;
    if (first) begin
      grp_size = size;
      seen = 0;
      picked = 0;
      target = group_target(size);
    end
    if (seen >= grp_size) return;
    if (picked < target)
      keep = draw_below(64'(grp_size - seen)) < 64'(target - picked);
    seen = seen + 1;
    if (!keep) return;
    e.kept_tag = tag;
    e.sample_index = picked;
    picked = picked + 1;
    e.last_of_sample = (picked == target);
    pending.push_back(e);
  endfunction

  function void check_kept(logic [31:0] tag, logic [15:0] idx, logic last);
    kept_item_t e;
    if (pending.size() == 0) begin
      $error("unexpected kept item, tag %h", tag);
      n_errors++;
      return;
    end
    e = pending.pop_front();
    if (tag !== e.kept_tag) begin
      $error("kept_tag: expected %h, got %h", e.kept_tag, tag);
      n_errors++;
    end
    if (idx !== e.sample_index) begin
      $error("sample_index: expected %0d, got %0d", e.sample_index, idx);
      n_errors++;
    end
    if (last !== e.last_of_sample) begin
      $error("last_of_sample: expected %0b, got %0b", e.last_of_sample, last);
      n_errors++;
    end
  endfunction
endclass

// ----- dv/tb_random_selection_sampler_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_random_selection_sampler_core: selection sampler testbench
// Drives groups of items under several percent/cap/seed settings, with
// random sender gaps and receiver stalls, and checks every kept item against
// a cycle-free model of the sampling rule.
// ----------------------------------------------------------------------------
module tb_random_selection_sampler_core;

  localparam int CYCLE_LIMIT = 2_000_000;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [rss_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [rss_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  int cycles = 0;
  int stall_mode = 0;
  bit driving = 1;
  int burst = 0;

  rss_in_if in_ch();
  rss_out_if out_ch();
  rss_sampler_sb sb = new();

  random_selection_sampler_core i_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_ch(in_ch), .out_ch(out_ch)
  );

  always #10 clk = ~clk;

  initial begin
    in_ch.valid = 0;
    in_ch.first_of_group = 0;
    in_ch.group_size = 0;
    in_ch.item_tag = 0;
    out_ch.ready = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
    if (out_ch.valid && out_ch.ready)
      sb.check_kept(out_ch.kept_tag, out_ch.sample_index, out_ch.last_of_sample);
  end

  // receiver stall pattern: phases of always-ready, random, and long stalls
  always @(negedge clk) begin
    if (!rst_n) out_ch.ready <= 0;
    else case (stall_mode)
      0: out_ch.ready <= 1;
      1: out_ch.ready <= ($urandom_range(0, 3) != 0);
      default: out_ch.ready <= ($urandom_range(0, 15) == 0);
    endcase
    if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
  end

  task automatic write_reg(logic [rss_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 0;
    sb.write_reg(idx, val);
  endtask

  task automatic send_item(logic first, logic [15:0] size, logic [31:0] tag);
    in_ch.valid <= 1;
    in_ch.first_of_group <= first;
    in_ch.group_size <= size;
    in_ch.item_tag <= tag;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_item(first, size, tag);
    @(negedge clk);
  endtask

  task automatic pause_sender();
    in_ch.valid <= 0;
    in_ch.first_of_group <= 1'($urandom);
    in_ch.group_size <= 16'($urandom);
    in_ch.item_tag <= $urandom;
    repeat ($urandom_range(1, 6)) @(negedge clk);
  endtask

  task automatic item(logic first, logic [15:0] size, logic [31:0] tag);
    if (burst == 0) begin
      if ($urandom_range(0, 2) != 0) pause_sender();
      burst = $urandom_range(1, 12);
    end
    burst--;
    send_item(first, size, tag);
  endtask

  task automatic send_group(logic [15:0] size, int count);
    for (int i = 0; i < count; i++)
      item(i == 0, size, $urandom);
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (sb.pending.size() != 0 && cycles < CYCLE_LIMIT) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  int sent;
  int sz;

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: stray items before any group, empty group, full keep
    item(1'b0, 16'hFFFF, 32'hFFFF_FFFF);
    item(1'b0, 16'd3, 32'h0);
    send_group(16'd0, 2);
    send_group(16'd1, 1);
    send_group(16'd3, 5);
    item(1'b1, 16'hFFFF, 32'hA5A5_5A5A);
    item(1'b1, 16'd2, 32'hFFFF_FFFF);
    item(1'b0, 16'd0, 32'h0);
    drain();
    write_reg(rss_pkg::CFG_PERCENT, 64'd0);
    write_reg(rss_pkg::CFG_MAX_PIC, 64'hFFFF);
    write_reg(rss_pkg::CFG_SEED, 64'hFFFF_FFFF_FFFF_FFFF);
    send_group(16'd4, 4);
    drain();
    write_reg(rss_pkg::CFG_PERCENT, 64'h7F);
    write_reg(rss_pkg::CFG_MAX_PIC, 64'd1);
    send_group(16'd5, 5);
    drain();
    write_reg(rss_pkg::CFG_PERCENT, 64'd1);
    write_reg(rss_pkg::CFG_MAX_PIC, 64'd0);
    send_group(16'd3, 3);
    // seed rewrite in the middle of a group
    drain();
    write_reg(rss_pkg::CFG_PERCENT, 64'd50);
    send_group(16'd6, 2);
    drain();
    write_reg(rss_pkg::CFG_SEED, {$urandom, $urandom});
    for (int i = 0; i < 4; i++) item(1'b0, 16'($urandom), $urandom);
    drain();

    sent = 0;
    for (int phase = 0; phase < 5; phase++) begin
      write_reg(rss_pkg::CFG_PERCENT, 64'((phase == 0) ? 100 : $urandom_range(0, 127)));
      write_reg(rss_pkg::CFG_MAX_PIC, 64'((phase < 2) ? 0 : $urandom_range(0, 8)));
      write_reg(rss_pkg::CFG_SEED, {$urandom, $urandom});
      while (sent < (phase + 1) * 160) begin
        case ($urandom_range(0, 9))
          0: sz = 32'($urandom & 16'hFFFF);
          1: sz = 0;
          default: sz = $urandom_range(1, 12);
        endcase
        if (sz > 12) begin
          // large size: a few items only, the rest never arrive
          send_group(16'(sz), $urandom_range(1, 4));
          sent += 4;
        end else begin
          send_group(16'(sz), sz + (($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0));
          sent += sz + 1;
        end
        if ($urandom_range(0, 15) == 0) item(1'b0, 16'($urandom), $urandom);
      end
      drain();
    end

    if (sb.n_errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      if (sb.pending.size() != 0) $error("%0d kept items never arrived", sb.pending.size());
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
rtl/rss_pkg.sv
rtl/rss_if.sv
rtl/rss_ctrl.sv
rtl/rss_dp.sv
rtl/random_selection_sampler_core.sv
dv/rss_sampler_sb.sv
dv/tb_random_selection_sampler_core.sv
